// ===== rtl/core/swa_pkg.sv =====
package swa_pkg;

  localparam int unsigned PriceW  = 32;
  localparam int unsigned WinLenW = 7;
  localparam logic [WinLenW-1:0] WinLenReset = 7'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } swa_state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;   // take the input beat, read the slot it lands in
    logic sub_old;    // drop the overwritten sample, store the new one
    logic add_new;    // add the new sample, advance slot and count
    logic div_step;   // one quotient bit
    logic load_out;   // move the quotient into the output register
  } swa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
  } swa_status_t;

endpackage

// ===== rtl/core/sliding_window_average.sv =====
// Moving average of unsigned Q16.16 price samples. Each accepted price beat
// is stored in a ring of window_length entries (zero acts as one, values above
// MAX_WINDOW act as MAX_WINDOW) and yields one result beat: the number of
// samples now held and the truncated mean of them. A new sample is accepted only
// after the last one has passed the SUB, ADD, DIV and DONE states, DIV being
// the radix-2 restoring divider, one quotient bit per cycle over the
// running-sum width. A finished result sits in an output register, so the
// next sample is taken while it waits. Writing window_length empties the
// window; write it only while the block is idle.
module sliding_window_average #(
  parameter int unsigned MAX_WINDOW = 64,
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [swa_pkg::WinLenW-1:0] cfg_wdata_i,
  input  logic                        price_valid_i,
  output logic                        price_ready_o,
  input  logic [swa_pkg::PriceW-1:0]  price_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [CntW-1:0]             sample_count_o,
  output logic [swa_pkg::PriceW-1:0]  average_o
);

  swa_pkg::swa_cmd_t    cmd;
  swa_pkg::swa_status_t status;

  swa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .price_valid_i  (price_valid_i),
    .price_ready_o  (price_ready_o),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  swa_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .price_i        (price_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_count_o (sample_count_o),
    .average_o      (average_o)
  );

endmodule

// ===== rtl/core/swa_ram.sv =====
module swa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/swa_dp.sv =====
module swa_dp #(
  parameter int unsigned MAX_WINDOW = 64,
  localparam int unsigned SlotW = $clog2(MAX_WINDOW),
  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1),
  localparam int unsigned SumW  = swa_pkg::PriceW + SlotW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swa_pkg::WinLenW-1:0]   cfg_wdata_i,
  input  logic [swa_pkg::PriceW-1:0]    price_i,
  input  swa_pkg::swa_cmd_t             cmd_i,
  output swa_pkg::swa_status_t          status_o,
  output logic [CntW-1:0]               sample_count_o,
  output logic [swa_pkg::PriceW-1:0]    average_o
);

  localparam int unsigned DivCntW = $clog2(SumW);

  logic [swa_pkg::WinLenW-1:0] win_len_q;
  logic [SlotW-1:0]            wslot_q, wslot_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [SumW-1:0]             sum_q, sum_d;
  logic [swa_pkg::PriceW-1:0]  price_q;
  logic [SumW-1:0]             dq_q, dq_d;
  logic [CntW-1:0]             rem_q, rem_d;
  logic [DivCntW-1:0]          div_cnt_q, div_cnt_d;
  logic [CntW-1:0]             cnt_out_q;
  logic [swa_pkg::PriceW-1:0]  avg_out_q;

  logic [CntW-1:0]             len;
  logic [SlotW-1:0]            slot_eff;
  logic [CntW-1:0]             slot_inc;
  logic [SumW-1:0]             sum_add;
  logic [swa_pkg::PriceW-1:0]  old_sample;
  logic [CntW:0]               trial;
  logic                        qbit;

  // zero means one sample, anything above the ring depth clamps to it
  always_comb begin
    if (win_len_q == '0) begin
      len = CntW'(1);
    end else if (32'(win_len_q) > MAX_WINDOW) begin
      len = CntW'(MAX_WINDOW);
    end else begin
      len = CntW'(win_len_q);
    end
  end

  assign slot_eff = (CntW'(wslot_q) >= len) ? '0 : wslot_q;
  assign slot_inc = CntW'(wslot_q) + CntW'(1);
  assign sum_add  = sum_q + SumW'(price_q);

  assign trial = {rem_q, dq_q[SumW-1]};
  assign qbit  = (trial >= {1'b0, fill_q});

  swa_ram #(
    .Width (swa_pkg::PriceW),
    .Depth (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sub_old),
    .waddr_i (wslot_q),
    .wdata_i (price_q),
    .re_i    (cmd_i.latch_in),
    .raddr_i (slot_eff),
    .rdata_o (old_sample)
  );

  always_comb begin
    wslot_d   = wslot_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    div_cnt_d = div_cnt_q;
    if (cmd_i.latch_in) begin
      wslot_d = slot_eff;
      if (fill_q > len) begin
        fill_d = len;
      end
    end
    if (cmd_i.sub_old && (fill_q == len)) begin
      sum_d = sum_q - SumW'(old_sample);
    end
    if (cmd_i.add_new) begin
      sum_d     = sum_add;
      dq_d      = sum_add;
      rem_d     = '0;
      div_cnt_d = '0;
      wslot_d   = (slot_inc >= len) ? '0 : SlotW'(slot_inc);
      if (fill_q < len) begin
        fill_d = fill_q + CntW'(1);
      end
    end
    if (cmd_i.div_step) begin
      rem_d     = qbit ? CntW'(trial - {1'b0, fill_q}) : CntW'(trial);
      dq_d      = {dq_q[SumW-2:0], qbit};
      div_cnt_d = div_cnt_q + DivCntW'(1);
    end
    // a register write empties the window
    if (cfg_we_i) begin
      wslot_d = '0;
      fill_d  = '0;
      sum_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= swa_pkg::WinLenReset;
      wslot_q   <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
      end
      wslot_q   <= wslot_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      price_q <= price_i;
    end
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (cmd_i.load_out) begin
      cnt_out_q <= fill_q;
      avg_out_q <= dq_q[swa_pkg::PriceW-1:0];
    end
  end

  assign status_o.div_last = (div_cnt_q == DivCntW'(SumW - 1));
  assign sample_count_o    = cnt_out_q;
  assign average_o         = avg_out_q;

endmodule

// ===== rtl/core/swa_ctrl.sv =====
module swa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 price_valid_i,
  output logic                 price_ready_o,
  output logic                 result_valid_o,
  input  logic                 result_ready_i,
  input  swa_pkg::swa_status_t status_i,
  output swa_pkg::swa_cmd_t    cmd_o
);

  swa_pkg::swa_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || result_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        if (price_valid_i) begin
          state_d = swa_pkg::ST_SUB;
        end
      end
      swa_pkg::ST_SUB: state_d = swa_pkg::ST_ADD;
      swa_pkg::ST_ADD: state_d = swa_pkg::ST_DIV;
      swa_pkg::ST_DIV: begin
        if (status_i.div_last) begin
          state_d = swa_pkg::ST_DONE;
        end
      end
      swa_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = swa_pkg::ST_IDLE;
        end
      end
      default: state_d = swa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    price_ready_o = 1'b0;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        price_ready_o   = 1'b1;
        cmd_o.latch_in  = price_valid_i;
      end
      swa_pkg::ST_SUB:  cmd_o.sub_old  = 1'b1;
      swa_pkg::ST_ADD:  cmd_o.add_new  = 1'b1;
      swa_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      swa_pkg::ST_DONE: cmd_o.load_out = out_free;
      default: begin
        cmd_o         = '0;
        price_ready_o = 1'b0;
      end
    endcase
  end

  // hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_valid_o = out_valid_q;

endmodule

// ===== rtl/core/swa_checker.sv =====
module swa_checker #(
  parameter int unsigned MAX_WINDOW = 64,
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1)
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        price_valid_i,
  input logic                        price_ready_o,
  input logic                        result_valid_o,
  input logic                        result_ready_i,
  input logic [CntW-1:0]             sample_count_o,
  input logic [swa_pkg::PriceW-1:0]  average_o
);

  logic price_beat;
  assign price_beat = price_valid_i && price_ready_o;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(sample_count_o) && $stable(average_o))
    else $error("result beat changed while stalled");

  // one sample at a time: busy right after a price beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    price_beat |=> !price_ready_o)
    else $error("price accepted while a sample is in work");

  // the divider still works on the sample, no result right after a price beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    price_beat |=> !$rose(result_valid_o))
    else $error("result appeared too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (sample_count_o != '0) && (32'(sample_count_o) <= MAX_WINDOW))
    else $error("sample count out of range");

endmodule

bind sliding_window_average swa_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_swa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .price_valid_i  (price_valid_i),
  .price_ready_o  (price_ready_o),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .sample_count_o (sample_count_o),
  .average_o      (average_o)
);
